@@ src/ntf_pkg.sv @@
package ntf_pkg;

  localparam int LOG_FRAC      = 24;
  localparam int EXP_ONE       = 30;
  localparam int NUM_W         = 44;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = NUM_W / DIV_PER_STAGE;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_RATIO = 2'd1;
  localparam logic [1:0] REG_DIV   = 2'd2;
  localparam logic [1:0] REG_REF   = 2'd3;

  typedef struct packed {
    logic               v;
    logic               dneg;
    logic               dzero;
    logic signed [20:0] k;
    logic [23:0]        f;
    logic [30:0]        p;
  } exp_stage_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    while (b > x) b = b >> 2;
    while (b != 64'd0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Constant 2^(2^-i) in Q2.30.
  function automatic logic [31:0] exp_c(input int i);
    logic [63:0] c;
    c = isqrt64(64'd1 << 61);
    for (int j = 1; j < i; j++) c = isqrt64(c << EXP_ONE);
    return c[31:0];
  endfunction

endpackage

@@ src/note_to_frequency_tuning.sv @@
// Channel  Direction  Signals                          Contents
// s        in         s_tvalid s_tready s_tdata[15:0]   note (signed Q8.8)
// m        out        m_tvalid m_tready m_tdata[31:0]   frequency (Q16.16)
//                     m_tuser[0]                        overflow
// cfg      in         cfg_we cfg_index cfg_data         register writes
//
// One item is accepted per cycle while the pipeline is not held and no log2 is running.
// The whole pipeline advances together and holds when a result waits on m_tready.
// A write of the octave ratio starts a log2 sequencer (a setup step, then one
// squaring per cycle until every fraction bit is done), and no item is accepted meanwhile.
// Reset is synchronous and restores the default registers.
module note_to_frequency_tuning (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // note
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // frequency
  output logic [0:0]  m_tuser,   // overflow
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NW = ntf_pkg::NUM_W;
  localparam int DS = ntf_pkg::DIV_STAGES;

  logic [31:0]        base_freq;
  logic [23:0]        octave_ratio;
  logic [15:0]        divisions;
  logic signed [15:0] reference_note;
  logic signed [28:0] log_l;

  logic        busy;
  logic        lstart;
  logic        ratio_wr;
  logic [4:0]  lcnt;
  logic [31:0] lm;
  logic [23:0] lfrac;
  logic [4:0]  lp;
  logic [4:0]  lp_comb;
  logic [63:0] lsq_full;
  logic [32:0] lsq;
  logic [23:0] lfrac_next;
  logic signed [5:0] lint;

  assign ratio_wr = cfg_we && (cfg_index == ntf_pkg::REG_RATIO);

  always_comb begin
    lp_comb = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (octave_ratio[i]) lp_comb = i[4:0];
    end
    lsq_full = 64'(lm) * 64'(lm);
    lsq = lsq_full[63:31];
    lfrac_next = lfrac;
    if (lsq[32]) lfrac_next[5'd23 - lcnt] = 1'b1;
    lint = $signed({1'b0, lp}) - 6'sd16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_freq      <= 32'd28835840;
      octave_ratio   <= 24'd131072;
      divisions      <= 16'd3072;
      reference_note <= 16'sd17664;
      log_l          <= 29'sd16777216;
      busy           <= 1'b0;
      lstart         <= 1'b0;
    end else begin
      lstart <= ratio_wr;
      if (cfg_we) begin
        case (cfg_index)
          ntf_pkg::REG_BASE: base_freq <= cfg_data;
          ntf_pkg::REG_RATIO: begin
            octave_ratio <= cfg_data[23:0];
            busy         <= 1'b1;
          end
          ntf_pkg::REG_DIV: divisions <= cfg_data[15:0];
          ntf_pkg::REG_REF: reference_note <= $signed(cfg_data[15:0]);
          default: ;
        endcase
      end
      if (lstart) begin
        lm     <= 32'({9'b0, octave_ratio} << (5'd31 - lp_comb));
        lp     <= lp_comb;
        lcnt   <= 5'd0;
        lfrac  <= 24'd0;
      end else if (busy) begin
        lm    <= lsq[32] ? lsq[32:1] : lsq[31:0];
        lfrac <= lfrac_next;
        lcnt  <= lcnt + 5'd1;
        if (lcnt == 5'd23) begin
          if (!ratio_wr) busy <= 1'b0;
          log_l <= $signed({lint[4:0], lfrac_next});
        end
      end
    end
  end

  logic en;
  logic acc;
  logic [15:0] dvs;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !busy;
  assign acc      = s_tvalid && s_tready;
  assign dvs      = (divisions == 16'd0) ? 16'd1 : divisions;

  logic               a_v;
  logic signed [16:0] a_d;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= acc;
    if (en) a_d <= 17'($signed(s_tdata)) - 17'(reference_note);
  end

  logic               dv_v    [0:DS];
  logic               dv_neg  [0:DS];
  logic               dv_dneg [0:DS];
  logic               dv_dz   [0:DS];
  logic [NW-1:0]      dv_q    [0:DS];
  logic [16:0]        dv_rem  [0:DS];
  logic signed [45:0] n_full;

  assign n_full = 46'(log_l) * 46'(a_d);

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= a_v;
    if (en) begin
      dv_neg[0]  <= n_full[45];
      dv_dneg[0] <= a_d[16];
      dv_dz[0]   <= (a_d == 17'sd0);
      dv_q[0]    <= n_full[45] ? NW'(-n_full) : n_full[NW-1:0];
      dv_rem[0]  <= 17'd0;
    end
  end

  for (genvar g = 0; g < DS; g++) begin : g_div
    logic [16:0]   r;
    logic [NW-1:0] n;
    always_comb begin
      r = dv_rem[g];
      n = dv_q[g];
      for (int s = 0; s < ntf_pkg::DIV_PER_STAGE; s++) begin
        r = {r[15:0], n[NW-1]};
        n = {n[NW-2:0], 1'b0};
        if (r >= {1'b0, dvs}) begin
          r    = r - {1'b0, dvs};
          n[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[g+1] <= 1'b0;
      else if (en) dv_v[g+1] <= dv_v[g];
      if (en) begin
        dv_neg[g+1]  <= dv_neg[g];
        dv_dneg[g+1] <= dv_dneg[g];
        dv_dz[g+1]   <= dv_dz[g];
        dv_q[g+1]    <= n;
        dv_rem[g+1]  <= r;
      end
    end
  end

  ntf_pkg::exp_stage_t ex [0:24];
  logic signed [44:0]  q0;
  logic signed [44:0]  qs;

  always_comb begin
    q0 = $signed({1'b0, dv_q[DS]});
    if (dv_neg[DS]) qs = -q0 - 45'(dv_rem[DS] != 17'd0);
    else qs = q0;
  end

  always_ff @(posedge clk) begin
    if (rst) ex[0].v <= 1'b0;
    else if (en) ex[0].v <= dv_v[DS];
    if (en) begin
      ex[0].dneg  <= dv_dneg[DS];
      ex[0].dzero <= dv_dz[DS];
      ex[0].k     <= qs[44:24];
      ex[0].f     <= qs[23:0];
      ex[0].p     <= 31'(64'd1 << ntf_pkg::EXP_ONE);
    end
  end

  for (genvar e = 1; e <= 24; e++) begin : g_exp
    localparam logic [31:0] CE = ntf_pkg::exp_c(e);
    logic [62:0] prod;
    assign prod = 63'(ex[e-1].p) * 63'(CE);
    always_ff @(posedge clk) begin
      if (rst) ex[e].v <= 1'b0;
      else if (en) ex[e].v <= ex[e-1].v;
      if (en) begin
        ex[e].dneg  <= ex[e-1].dneg;
        ex[e].dzero <= ex[e-1].dzero;
        ex[e].k     <= ex[e-1].k;
        ex[e].f     <= ex[e-1].f;
        ex[e].p     <= ex[e-1].f[24-e] ? prod[60:30] : ex[e-1].p;
      end
    end
  end

  logic               mu_v;
  logic               mu_dneg;
  logic               mu_dz;
  logic signed [21:0] mu_s;
  logic [62:0]        mu_prod;

  always_ff @(posedge clk) begin
    if (rst) mu_v <= 1'b0;
    else if (en) mu_v <= ex[24].v;
    if (en) begin
      mu_dneg <= ex[24].dneg;
      mu_dz   <= ex[24].dzero;
      mu_s    <= 22'(ex[24].k) - 22'sd30;
      mu_prod <= 63'(base_freq) * 63'(ex[24].p);
    end
  end

  logic [94:0]        wide;
  logic [62:0]        rsh;
  logic signed [21:0] nsh;
  logic [31:0]        o_freq;
  logic               o_ovf;

  always_comb begin
    wide = 95'(mu_prod) << mu_s[4:0];
    nsh  = -mu_s;
    rsh  = (nsh >= 22'sd64) ? 63'd0 : (mu_prod >> nsh[5:0]);
    if (!mu_s[21]) begin
      if (mu_s >= 22'sd32 || (|wide[94:32])) begin
        o_freq = 32'hFFFF_FFFF;
        o_ovf  = 1'b1;
      end else begin
        o_freq = wide[31:0];
        o_ovf  = 1'b0;
      end
    end else if (|rsh[62:32]) begin
      o_freq = 32'hFFFF_FFFF;
      o_ovf  = 1'b1;
    end else begin
      o_freq = rsh[31:0];
      o_ovf  = 1'b0;
    end
    if (base_freq == 32'd0) begin
      o_freq = 32'd0;
      o_ovf  = 1'b0;
    end else if (octave_ratio == 24'd0) begin
      if (mu_dz) begin
        o_freq = base_freq;
        o_ovf  = 1'b0;
      end else if (mu_dneg) begin
        o_freq = 32'hFFFF_FFFF;
        o_ovf  = 1'b1;
      end else begin
        o_freq = 32'd0;
        o_ovf  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= mu_v;
    if (en) begin
      m_tdata    <= o_freq;
      m_tuser[0] <= o_ovf;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst) busy |-> !s_tready)
    else $error("item accepted during log2 computation");
  a_ovf_max: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'hFFFF_FFFF))
    else $error("overflow flag without saturated frequency");
  a_ratio_start: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == ntf_pkg::REG_RATIO) |=> (busy && lstart))
    else $error("ratio write did not start log2 sequencer");
`endif

endmodule
